// ===== design/ilst_pkg.sv =====
// Shared types, codes and sizes for the indexed list store.
package ilst_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;

  // Field widths fixed by the interface
  localparam int CMD_W  = 4;
  localparam int IDXF_W = 5;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int POSF_W = 4;
  localparam int CNTF_W = 5;

  // Internal widths follow the depth
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = (CNT_W > IDXF_W) ? CNT_W : IDXF_W;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SET        = 4'd5;
  localparam logic [CMD_W-1:0] CMD_GET        = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FIND       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd8;
  localparam logic [CMD_W-1:0] CMD_FRONT      = 4'd9;
  localparam logic [CMD_W-1:0] CMD_BACK       = 4'd10;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS  = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDXF_W-1:0] index;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  data;
    logic [POSF_W-1:0] found_position;
    logic [CNTF_W-1:0] count;
  } rsp_t;

  // Mask an interface value down to an element
  function automatic logic [WIDTH-1:0] to_elem(input logic [VAL_W-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[WIDTH-1:0];
  endfunction

  // Widen or cut an element to the interface data field
  function automatic logic [VAL_W-1:0] to_data(input logic [WIDTH-1:0] e);
    logic [63:0] wide;
    wide = 64'(e);
    return wide[VAL_W-1:0];
  endfunction

endpackage

// ===== design/ilst_cell.sv =====
// One storage cell of the list row: holds an element and its match flag.
module ilst_cell
  import ilst_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [WIDTH-1:0] load_value,
  input  logic [WIDTH-1:0] cmp_value,
  input  logic [WIDTH-1:0] left_data,
  input  logic [WIDTH-1:0] right_data,
  output logic [WIDTH-1:0] data,
  output logic             match
);

  logic [WIDTH-1:0] data_next;

  always_comb begin
    unique case (ctrl.op)
      CELL_LOAD:  data_next = load_value;
      CELL_LEFT:  data_next = left_data;
      CELL_RIGHT: data_next = right_data;
      default:    data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    // capture the compare against the contents seen at command transfer
    if (ctrl.cmp_en) begin
      match <= (data == cmp_value);
    end
  end

endmodule

// ===== design/indexed_list_store_core.sv =====
// Top level of the indexed list store: command control over a row of cells.
//
//  channel | valid     | stall     | payload | direction
//  --------+-----------+-----------+---------+----------
//  command | cmd_valid | cmd_stall | cmd     | in
//  result  | rsp_valid | rsp_stall | rsp     | out
//
// The transfer cycle latches each command and lets every cell compare its
// element with the value; once the result register is free to be written, the
// control shifts, loads or reads the cell row and writes the result register.
// No new command is taken while one is pending.
// Reset clears the count, the busy flag and the result valid; the cells are
// left as they are.
// A stalled result holds the pending command, and with it the command input.
module indexed_list_store_core
  import ilst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t             cmd_r;
  logic             busy;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_next;

  cell_ctrl_t       ctrl      [DEPTH];
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [WIDTH-1:0] left_in   [DEPTH];
  logic [WIDTH-1:0] right_in  [DEPTH];
  logic [DEPTH-1:0] match;

  logic             accept;
  logic             exec;
  logic [WIDTH-1:0] load_value;
  logic [WIDTH-1:0] cmp_value;
  logic [CW-1:0]    c;
  logic [CW-1:0]    p;
  logic [CW-1:0]    last;
  logic             full;
  logic             empty;
  logic             ins_en;
  logic             rem_en;
  logic             set_en;
  logic [CW-1:0]    op_pos;
  logic [ST_W-1:0]  st;
  logic [VAL_W-1:0] d;
  logic [IDX_W-1:0] find_pos;
  logic             find_hit;
  rsp_t             rsp_next;

  assign cmd_stall = busy;
  assign accept    = cmd_valid && !cmd_stall;
  assign exec      = busy && (!rsp_valid || !rsp_stall);

  assign load_value = to_elem(cmd_r.value);
  assign cmp_value  = to_elem(cmd.value);

  assign c     = CW'(count_r);
  assign p     = CW'(cmd_r.index);
  assign last  = c - CW'(1);
  assign full  = (c == CW'(DEPTH));
  assign empty = (c == '0);

  // First match among held entries, lowest position wins
  always_comb begin
    find_hit = 1'b0;
    find_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i] && (CW'(i) < c)) begin
        find_hit = 1'b1;
        find_pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    st         = ST_OK;
    d          = '0;
    count_next = count_r;
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    set_en     = 1'b0;
    op_pos     = p;
    unique case (cmd_r.command)
      CMD_PUSH_BACK: begin
        op_pos = c;
        if (full) st = ST_FULL;
        else ins_en = 1'b1;
      end
      CMD_PUSH_FRONT: begin
        op_pos = '0;
        if (full) st = ST_FULL;
        else ins_en = 1'b1;
      end
      CMD_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          d          = to_data(cell_data[last[IDX_W-1:0]]);
          count_next = count_r - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (p > c) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else ins_en = 1'b1;
      end
      CMD_REMOVE: begin
        if (p >= c) begin
          st = ST_RANGE;
        end else begin
          rem_en     = 1'b1;
          count_next = count_r - CNT_W'(1);
        end
      end
      CMD_SET: begin
        if (p >= c) st = ST_RANGE;
        else set_en = 1'b1;
      end
      CMD_GET: begin
        if (p >= c) st = ST_RANGE;
        else d = to_data(cell_data[p[IDX_W-1:0]]);
      end
      CMD_FIND: begin
        if (!find_hit) st = ST_MISS;
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      CMD_FRONT: begin
        if (empty) st = ST_EMPTY;
        else d = to_data(cell_data[0]);
      end
      CMD_BACK: begin
        if (empty) st = ST_EMPTY;
        else d = to_data(cell_data[last[IDX_W-1:0]]);
      end
      default: begin
      end
    endcase
    if (ins_en) count_next = count_r + CNT_W'(1);
  end

  always_comb begin
    rsp_next.status = st;
    rsp_next.data   = d;
    rsp_next.count  = CNTF_W'(count_next);
    if (cmd_r.command == CMD_FIND && find_hit) begin
      rsp_next.found_position = POSF_W'(find_pos);
    end else begin
      rsp_next.found_position = '0;
    end
  end

  // Per-cell moves: open a gap and load on insert, close it on remove, load in place on set
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].cmp_en = accept;
      ctrl[i].op     = CELL_HOLD;
      if (exec) begin
        if ((ins_en || set_en) && CW'(i) == op_pos) begin
          ctrl[i].op = CELL_LOAD;
        end else if (ins_en && CW'(i) > op_pos && CW'(i) <= c) begin
          ctrl[i].op = CELL_LEFT;
        end else if (rem_en && CW'(i) >= op_pos && (CW'(i) + CW'(1)) < c) begin
          ctrl[i].op = CELL_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = load_value;
    end else begin : g_mid
      assign left_in[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in[g] = cell_data[g];
    end else begin : g_body
      assign right_in[g] = cell_data[g+1];
    end

    ilst_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .load_value (load_value),
      .cmp_value  (cmp_value),
      .left_data  (left_in[g]),
      .right_data (right_in[g]),
      .data       (cell_data[g]),
      .match      (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      count_r   <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end
      if (exec) begin
        rsp_valid <= 1'b1;
        count_r   <= count_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

  // a pending result always matches the held count
  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.count == CNTF_W'(count_r)))
    else $error("result count differs from held count");

  // a full report leaves the list full, an empty report leaves it empty
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (count_r == CNT_W'(DEPTH)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |-> (count_r == '0))
    else $error("empty status with entries held");

  // a pending command with a free result slot completes on the next edge
  a_exec: assert property (@(posedge clk) disable iff (rst)
    (busy && !rsp_valid) |=> (rsp_valid && !busy))
    else $error("pending command did not complete");

endmodule
